>>> hw/rtl/pmdfr_pkg.sv
package pmdfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int TICK_W    = 9;
  localparam int OUT_W     = 16;
  localparam int OUT_PAD_W = OUT_W - BYTE_W - LEN_W;

  localparam logic [BYTE_W-1:0] CH_PLUS     = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS    = 8'h2D;
  localparam logic [TICK_W-1:0] TICK_MAX    = 9'd511;
  localparam logic [7:0]        LIMIT_RESET = 8'd1;

  // input kinds carried on in_tuser
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_PLUS1,
    FR_BODY,
    FR_MINUS1
  } framer_t;

  typedef enum logic [2:0] {
    C_WAIT,
    C_PUT2,
    C_EMIT_RD,
    C_EMIT_LD,
    C_EMIT_EMPTY
  } ctrl_state_t;

  typedef struct packed {
    logic take;          // latch the incoming byte
    logic tick;          // count one timer tick
    logic clr_ticks;     // a byte arrived
    logic idx_clear;     // frame opened
    logic wr_en;
    logic wr_minus;      // write '-' instead of a data byte
    logic wr_latched;    // write the latched byte
    logic rd_start;
    logic rd_next;
    logic out_load;
    logic out_empty;
  } cmd_t;

  typedef struct packed {
    logic is_plus;
    logic is_minus;
    logic ticks_over;
    logic idx_zero;
    logic rd_last;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/pmdfr_ctrl.sv
module pmdfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_ready,
  input  pmdfr_pkg::status_t sts,
  output pmdfr_pkg::cmd_t    cmd
);

  pmdfr_pkg::ctrl_state_t state_r, state_nxt;
  pmdfr_pkg::framer_t     framer_r, framer_nxt;
  logic                   accept;

  assign in_ready = (state_r == pmdfr_pkg::C_WAIT);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pmdfr_pkg::C_WAIT;
      framer_r <= pmdfr_pkg::FR_IDLE;
    end else begin
      state_r  <= state_nxt;
      framer_r <= framer_nxt;
    end
  end

  // next state of both the sequencer and the framer
  always_comb begin
    state_nxt  = state_r;
    framer_nxt = framer_r;
    case (state_r)
      pmdfr_pkg::C_WAIT: begin
        if (accept) begin
          if (in_kind == pmdfr_pkg::KIND_TICK) begin
            if (sts.ticks_over) framer_nxt = pmdfr_pkg::FR_IDLE;
          end else if (sts.is_plus) begin
            case (framer_r)
              pmdfr_pkg::FR_IDLE:   framer_nxt = pmdfr_pkg::FR_PLUS1;
              pmdfr_pkg::FR_PLUS1:  framer_nxt = pmdfr_pkg::FR_BODY;
              pmdfr_pkg::FR_BODY:   framer_nxt = pmdfr_pkg::FR_BODY;
              pmdfr_pkg::FR_MINUS1: begin
                framer_nxt = pmdfr_pkg::FR_BODY;
                state_nxt  = pmdfr_pkg::C_PUT2;
              end
              default: framer_nxt = pmdfr_pkg::FR_IDLE;
            endcase
          end else if (sts.is_minus) begin
            case (framer_r)
              pmdfr_pkg::FR_BODY: framer_nxt = pmdfr_pkg::FR_MINUS1;
              pmdfr_pkg::FR_MINUS1: begin
                framer_nxt = pmdfr_pkg::FR_IDLE;
                state_nxt  = sts.idx_zero ? pmdfr_pkg::C_EMIT_EMPTY : pmdfr_pkg::C_EMIT_RD;
              end
              default: framer_nxt = pmdfr_pkg::FR_BODY;
            endcase
          end else begin
            case (framer_r)
              pmdfr_pkg::FR_BODY: framer_nxt = pmdfr_pkg::FR_BODY;
              pmdfr_pkg::FR_MINUS1: begin
                framer_nxt = pmdfr_pkg::FR_BODY;
                state_nxt  = pmdfr_pkg::C_PUT2;
              end
              default: framer_nxt = pmdfr_pkg::FR_IDLE;
            endcase
          end
        end
      end
      pmdfr_pkg::C_PUT2:    state_nxt = pmdfr_pkg::C_WAIT;
      pmdfr_pkg::C_EMIT_RD: state_nxt = pmdfr_pkg::C_EMIT_LD;
      pmdfr_pkg::C_EMIT_LD: begin
        if (sts.out_free) begin
          state_nxt = sts.rd_last ? pmdfr_pkg::C_WAIT : pmdfr_pkg::C_EMIT_RD;
        end
      end
      pmdfr_pkg::C_EMIT_EMPTY: begin
        if (sts.out_free) state_nxt = pmdfr_pkg::C_WAIT;
      end
      default: state_nxt = pmdfr_pkg::C_WAIT;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    case (state_r)
      pmdfr_pkg::C_WAIT: begin
        if (accept) begin
          cmd.take = 1'b1;
          if (in_kind == pmdfr_pkg::KIND_TICK) begin
            cmd.tick = 1'b1;
          end else begin
            cmd.clr_ticks = 1'b1;
            if (sts.is_plus && framer_r == pmdfr_pkg::FR_PLUS1) begin
              cmd.idx_clear = 1'b1;
            end else if (sts.is_minus) begin
              if (framer_r == pmdfr_pkg::FR_MINUS1) begin
                cmd.rd_start = 1'b1;
              end else if (framer_r != pmdfr_pkg::FR_BODY) begin
                cmd.wr_en    = 1'b1;
                cmd.wr_minus = 1'b1;
              end
            end else if (framer_r == pmdfr_pkg::FR_BODY) begin
              cmd.wr_en = 1'b1;
            end else if (framer_r == pmdfr_pkg::FR_MINUS1) begin
              // escaped '-' goes in first, the byte follows next cycle
              cmd.wr_en    = 1'b1;
              cmd.wr_minus = 1'b1;
            end
          end
        end
      end
      pmdfr_pkg::C_PUT2: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_latched = 1'b1;
      end
      pmdfr_pkg::C_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.rd_next  = 1'b1;
        end
      end
      pmdfr_pkg::C_EMIT_EMPTY: begin
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_empty = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> hw/rtl/pmdfr_dpath.sv
module pmdfr_dpath #(
  parameter int BODY_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pmdfr_pkg::BYTE_W-1:0]  rx_byte,
  input  logic                          cfg_wr_en,
  input  logic [7:0]                    cfg_wr_data,
  input  pmdfr_pkg::cmd_t               cmd,
  output pmdfr_pkg::status_t            sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [pmdfr_pkg::BYTE_W-1:0]  out_byte,
  output logic [pmdfr_pkg::LEN_W-1:0]   out_len,
  output logic                          out_last,
  output logic                          out_empty
);

  localparam int IW = $clog2(BODY_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(BODY_DEPTH - 1);

  logic [pmdfr_pkg::BYTE_W-1:0] mem [BODY_DEPTH];

  logic [IW-1:0]                idx_r, idx_nxt;
  logic [IW-1:0]                rd_k_r, rd_k_nxt;
  logic [pmdfr_pkg::TICK_W-1:0] ticks_r, ticks_nxt;
  logic [7:0]                   limit_r;
  logic                         out_valid_r;
  logic [pmdfr_pkg::BYTE_W-1:0] byte_r;
  logic [pmdfr_pkg::BYTE_W-1:0] rd_data_r;
  logic [pmdfr_pkg::BYTE_W-1:0] wr_data;
  logic [pmdfr_pkg::BYTE_W-1:0] out_byte_r;
  logic [pmdfr_pkg::LEN_W-1:0]  out_len_r;
  logic                         out_last_r;
  logic                         out_empty_r;

  always_comb begin
    if (cmd.wr_minus)        wr_data = pmdfr_pkg::CH_MINUS;
    else if (cmd.wr_latched) wr_data = byte_r;
    else                     wr_data = rx_byte;
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clear) begin
      idx_nxt = '0;
    end else if (cmd.wr_en && idx_r != LAST_IDX) begin
      idx_nxt = idx_r + IW'(1);   // final slot is overwritten once full
    end
  end

  always_comb begin
    ticks_nxt = ticks_r;
    if (cmd.clr_ticks) begin
      ticks_nxt = '0;
    end else if (cmd.tick && ticks_r != pmdfr_pkg::TICK_MAX) begin
      ticks_nxt = ticks_r + pmdfr_pkg::TICK_W'(1);
    end
  end

  always_comb begin
    rd_k_nxt = rd_k_r;
    if (cmd.rd_start)     rd_k_nxt = '0;
    else if (cmd.rd_next) rd_k_nxt = rd_k_r + IW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      ticks_r     <= '0;
      limit_r     <= pmdfr_pkg::LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      ticks_r <= ticks_nxt;
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (cmd.out_load)     out_valid_r <= 1'b1;
      else if (out_ready)   out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_k_r <= rd_k_nxt;
    if (cmd.take) byte_r <= rx_byte;
    if (cmd.out_load) begin
      out_byte_r  <= cmd.out_empty ? '0 : rd_data_r;
      out_len_r   <= pmdfr_pkg::LEN_W'(idx_r);
      out_last_r  <= cmd.out_empty | sts.rd_last;
      out_empty_r <= cmd.out_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[idx_r] <= wr_data;
    rd_data_r <= mem[rd_k_r];
  end

  assign sts.is_plus    = (rx_byte == pmdfr_pkg::CH_PLUS);
  assign sts.is_minus   = (rx_byte == pmdfr_pkg::CH_MINUS);
  assign sts.ticks_over = (ticks_r > {1'b0, limit_r});
  assign sts.idx_zero   = (idx_r == '0);
  assign sts.rd_last    = ((rd_k_r + IW'(1)) == idx_r);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_len   = out_len_r;
  assign out_last  = out_last_r;
  assign out_empty = out_empty_r;

endmodule

>>> hw/rtl/plus_minus_delimited_frame_receiver.sv
// channel   dir  tdata                                       tuser          tlast
// in_       in   [7:0] rx_byte                               cmd (1 = tick) -
// out_      out  [7:0] body_byte, [13:8] body_length, pad 0  empty_frame    last_of_frame
// cfg_      in   [7:0] idle_tick_limit (write only)          -              -
//
// a tick or most bytes are handled in C_WAIT alone; a byte after a lone '-' also
// needs C_PUT2, as the '-' and the byte are two writes to the body store's one write port
// closing "--" then walks the store, each body byte a registered read then an
// output load that waits out any out_ stall; an empty frame is one output load
// rst_n is synchronous; the body store is not cleared, the write index is
// in_tready stays low while a frame is being sent out
module plus_minus_delimited_frame_receiver #(
  parameter int BODY_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] rx_byte
  input  logic                        in_tuser,   // [0] cmd
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pmdfr_pkg::OUT_W-1:0] out_tdata,  // [7:0] body_byte, [13:8] body_length
  output logic                        out_tuser,  // [0] empty_frame
  output logic                        out_tlast,
  input  logic                        cfg_wr_en,
  input  logic [7:0]                  cfg_wr_data
);

  pmdfr_pkg::cmd_t    cmd;
  pmdfr_pkg::status_t sts;
  logic [pmdfr_pkg::BYTE_W-1:0] out_byte;
  logic [pmdfr_pkg::LEN_W-1:0]  out_len;

  pmdfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_kind  (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pmdfr_dpath #(
    .BODY_DEPTH (BODY_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_byte     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_byte    (out_byte),
    .out_len     (out_len),
    .out_last    (out_tlast),
    .out_empty   (out_tuser)
  );

  assign out_tdata = {{pmdfr_pkg::OUT_PAD_W{1'b0}}, out_len, out_byte};

endmodule

>>> hw/rtl/pmdfr_chk.sv
module pmdfr_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [pmdfr_pkg::OUT_W-1:0] out_tdata,
  input logic                        out_tuser,
  input logic                        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // an empty frame is a single closing transfer with zero payload
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == '0)
    else $error("empty frame malformed");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[pmdfr_pkg::OUT_W-1:pmdfr_pkg::BYTE_W+pmdfr_pkg::LEN_W] == '0)
    else $error("tdata padding not zero");

  // a tick never starts a result
  a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser && !out_tvalid |=> !out_tvalid)
    else $error("tick produced a result");

endmodule

bind plus_minus_delimited_frame_receiver pmdfr_chk u_pmdfr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

>>> dv/tb_plus_minus_delimited_frame_receiver.sv
`timescale 1ns / 1ps

module tb_plus_minus_delimited_frame_receiver;
  import pmdfr_pkg::*;

  localparam int          BODY_DEPTH    = 64;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 2000000;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic [5:0] body_length;
    logic       last_of_frame;
    logic       empty_frame;
  } body_result_t;

  // tracks the framer and holds the body bytes still owed by the block
  class frame_body_checker;
    logic [7:0]     tick_limit;
    framer_t        fstate;
    int unsigned    wr_idx;
    int unsigned    ticks;
    logic [7:0]     store [BODY_DEPTH];
    body_result_t   owed_results[$];
    int unsigned    mismatches;

    function new();
      tick_limit  = LIMIT_RESET;
      fstate      = FR_IDLE;
      wr_idx      = 0;
      ticks       = 0;
      mismatches  = 0;
    endfunction

    function void set_limit(logic [7:0] v);
      tick_limit = v;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // the last slot is overwritten once the index has saturated
    function void put(logic [7:0] v);
      store[wr_idx] = v;
      if (wr_idx < BODY_DEPTH - 1) wr_idx++;
    endfunction

    function void absorb(logic [7:0] v);
      if (fstate == FR_BODY || fstate == FR_MINUS1) begin
        if (fstate == FR_MINUS1) put(CH_MINUS);
        fstate = FR_BODY;
        put(v);
      end else begin
        fstate = FR_IDLE;
      end
    endfunction

    function void emit_body();
      body_result_t r;
      if (wr_idx == 0) begin
        r = {8'h00, 6'd0, 1'b1, 1'b1};
        owed_results.push_back(r);
        return;
      end
      for (int k = 0; k < wr_idx; k++) begin
        r.body_byte     = store[k];
        r.body_length   = 6'(wr_idx);
        r.last_of_frame = (k == wr_idx - 1);
        r.empty_frame   = 1'b0;
        owed_results.push_back(r);
      end
    endfunction

    function void accept_rx_item(logic kind, logic [7:0] b);
      if (kind == KIND_TICK) begin
        if (ticks > tick_limit) fstate = FR_IDLE;
        if (ticks < TICK_MAX) ticks++;
        return;
      end
      ticks = 0;
      if (b == CH_PLUS) begin
        case (fstate)
          FR_IDLE: fstate = FR_PLUS1;
          FR_PLUS1: begin
            fstate = FR_BODY;
            wr_idx = 0;
          end
          default: absorb(b);
        endcase
      end else if (b == CH_MINUS) begin
        case (fstate)
          FR_BODY: fstate = FR_MINUS1;
          FR_MINUS1: begin
            fstate = FR_IDLE;
            emit_body();
          end
          // a lone '-' outside the body appends at the kept index
          default: begin
            fstate = FR_BODY;
            absorb(b);
          end
        endcase
      end else begin
        absorb(b);
      end
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    function void check_body_result(logic [7:0] got_byte, logic [5:0] got_len,
                                    logic got_last, logic got_empty);
      body_result_t want;
      if (owed_results.size() == 0) begin
        report("unexpected transfer, body_byte", 0, got_byte);
        return;
      end
      want = owed_results.pop_front();
      if (got_byte !== want.body_byte) report("body_byte", want.body_byte, got_byte);
      if (got_len !== want.body_length) report("body_length", want.body_length, got_len);
      if (got_last !== want.last_of_frame)
        report("last_of_frame", want.last_of_frame, got_last);
      if (got_empty !== want.empty_frame) report("empty_frame", want.empty_frame, got_empty);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = 8'h00;
  logic                 in_tuser = KIND_BYTE;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_wr_en = 1'b0;
  logic [7:0]           cfg_wr_data = 8'h00;

  frame_body_checker    bodies = new();
  rx_item_t             stim[$];
  int unsigned          in_gap_odds = 4;
  int unsigned          out_gap_odds = 4;
  bit                   hold_out = 1'b0;

  plus_minus_delimited_frame_receiver #(
    .BODY_DEPTH (BODY_DEPTH)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      bodies.check_body_result(out_tdata[7:0], out_tdata[13:8], out_tlast, out_tuser);
  end

  // result side: short random stalls, or one long hold-off on request
  initial begin : out_side
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_out = 1'b0;
        out_tready <= 1'b1;
      end else if (out_gap_odds != 0 && $urandom_range(1, out_gap_odds) == 1) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void add_byte(logic [7:0] b);
    stim.push_back({KIND_BYTE, b});
  endfunction

  function automatic void add_ticks(int n);
    repeat (n) stim.push_back({KIND_TICK, 8'($urandom_range(0, 255))});
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_MINUS);
    return b;
  endfunction

  // body content: escaped '-', stray '+' and the odd tick mixed into random bytes
  function automatic void add_body(int len);
    int k = 0;
    int r;
    while (k < len) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        add_byte(CH_MINUS);
        add_byte(plain_byte());
        k += 2;
      end else if (r < 18) begin
        add_byte(CH_PLUS);
        k++;
      end else if (r < 22) begin
        add_ticks(1);
      end else begin
        add_byte(plain_byte());
        k++;
      end
    end
  endfunction

  function automatic void add_frame(int len);
    add_byte(CH_PLUS);
    add_byte(CH_PLUS);
    add_body(len);
    add_byte(CH_MINUS);
    add_byte(CH_MINUS);
  endfunction

  function automatic void add_random_run(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      add_frame(($urandom_range(0, 19) == 0) ? $urandom_range(55, 75) : $urandom_range(0, 12));
    end else if (r < 77) begin
      // inside an open frame, ticks just at or just past a limit under 20, else 3
      add_byte(CH_PLUS);
      add_byte(CH_PLUS);
      add_body($urandom_range(0, 4));
      add_ticks((lim < 20) ? $urandom_range(lim + 1, lim + 2) : 3);
      if ($urandom_range(0, 1)) begin
        add_byte(CH_MINUS);
        add_byte(CH_MINUS);
      end
    end else if (r < 90) begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0:       add_byte(CH_PLUS);
          1:       add_byte(CH_MINUS);
          2:       add_ticks(1);
          default: add_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      // broken opening, then dashes that append at the kept index and close
      add_byte(CH_PLUS);
      add_byte(plain_byte());
      repeat (3) add_byte(CH_MINUS);
    end
  endfunction

  task automatic send_stim();
    rx_item_t it;
    while (stim.size() > 0) begin
      it = stim.pop_front();
      if (in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      in_tvalid <= 1'b1;
      in_tuser  <= it.cmd;
      in_tdata  <= it.data;
      do @(posedge clk); while (!in_tready);
      bodies.accept_rx_item(it.cmd, it.data);
      @(negedge clk);
    end
    in_tvalid <= 1'b0;
  endtask

  // a byte with no result may still be in the pipe when the queue runs dry
  task automatic settle();
    while (bodies.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    bodies.set_limit(v);
  endtask

  task automatic run_phase(logic [7:0] lim, int items, int unsigned in_odds,
                           int unsigned out_odds, bit squeeze, int burst);
    int goal;
    settle();
    write_limit(lim);
    in_gap_odds  = in_odds;
    out_gap_odds = out_odds;
    if (squeeze) begin
      // long enough to saturate the write index
      hold_out = 1'b1;
      add_frame(66);
    end
    if (burst != 0) begin
      add_byte(CH_PLUS);
      add_byte(CH_PLUS);
      add_byte(plain_byte());
      add_byte(plain_byte());
      add_ticks(burst);
      repeat (3) add_byte(CH_MINUS);
    end
    goal = stim.size() + items;
    while (stim.size() < goal) add_random_run(lim);
    send_stim();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty frame
    add_byte(CH_PLUS);
    add_byte(CH_PLUS);
    add_byte(CH_MINUS);
    add_byte(CH_MINUS);
    // byte extremes, '-' escaping a '+'
    add_byte(CH_PLUS);
    add_byte(CH_PLUS);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CH_MINUS);
    add_byte(CH_PLUS);
    add_byte(CH_MINUS);
    add_byte(CH_MINUS);
    // '-' while idle carries on from the kept index
    add_byte(CH_MINUS);
    add_byte(8'h7F);
    add_byte(CH_MINUS);
    add_byte(CH_MINUS);
    // tick timeout inside a frame at the reset limit
    add_byte(CH_PLUS);
    add_byte(CH_PLUS);
    add_byte(8'h55);
    add_ticks(3);
    repeat (3) add_byte(CH_MINUS);
    send_stim();

    run_phase(8'd1, 10, 4, 4, 1'b0, 0);
    run_phase(8'd0, 10, 3, 2, 1'b0, 0);
    run_phase(8'd255, 2, 5, 0, 1'b1, 257);
    run_phase(8'($urandom_range(2, 20)), 10, 0, 3, 1'b0, 0);
    run_phase(8'd3, 8, 0, 0, 1'b0, 0);
    settle();

    if (bodies.mismatches == 0 && bodies.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
